// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tch_pkg.sv =====
// widths, constants and codes for the throttle cruise hold block
// no dependencies
`timescale 1ns / 1ps

package tch_pkg;

    localparam int ADC_BITS = 12;
    localparam int LEVEL_W  = ADC_BITS + 8;
    localparam int NUM_W    = LEVEL_W + 3;
    localparam int GAIN_W   = 32;
    localparam int ACC_W    = LEVEL_W + GAIN_W;
    localparam int MUL_W    = LEVEL_W;
    localparam int CNT_W    = $clog2(NUM_W + 1);
    localparam int DUTY_W   = 16;
    localparam int MODE_W   = 3;
    localparam int RC_W     = 9;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 5;

    localparam int THR_W    = 15;
    localparam int DGAIN_W  = 24;
    localparam int RET_W    = 8;

    localparam logic [DUTY_W-1:0] DUTY_ONE  = 16'd32768;
    localparam logic [RC_W-1:0]   RC_MAX    = 9'd511;
    localparam int                DIV_BY    = 5;
    localparam int                MAP_SHIFT = 24;
    localparam int                DB_SHIFT  = 16;

    localparam logic [ADC_BITS-1:0] MAP_START_RST  = ADC_BITS'(1117);
    localparam logic [GAIN_W-1:0]   MAP_GAIN_RST   = 32'd824053;
    localparam logic [THR_W-1:0]    DEAD_THR_RST   = 15'd4915;
    localparam logic [DGAIN_W-1:0]  DEAD_GAIN_RST  = 24'd77101;
    localparam logic [DUTY_W-1:0]   HOLD_BORDER_RST = 16'd9830;
    localparam logic [RET_W-1:0]    RET_TICKS_RST  = 8'd20;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE     = 3'd0,
        MODE_THROTTLE = 3'd1,
        MODE_RELEASED = 3'd2,
        MODE_PEAK     = 3'd3,
        MODE_HOLD     = 3'd4,
        MODE_CANCEL   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        REG_USE_FILTER  = 3'd0,
        REG_MAP_START   = 3'd1,
        REG_MAP_GAIN    = 3'd2,
        REG_DEAD_THR    = 3'd3,
        REG_DEAD_GAIN   = 3'd4,
        REG_HOLD_BORDER = 3'd5,
        REG_RET_TICKS   = 3'd6
    } reg_idx_t;

endpackage

// ===== hdl/throttle_cruise_hold.sv =====
// throttle conditioning and cruise hold state machine, top level
// depends on tch_pkg
`timescale 1ns / 1ps

// One adc_sample item in, one duty/mode item out. Items are handled one at a time
// through a bit-serial divide-by-five (filter) and one shared shift-add multiplier
// (map and deadband), one bit per cycle. An item waits in its update state while an
// earlier result is still held by result_ready; sample_ready returns once the
// result is in the output register, which may still wait on result_ready.
module throttle_cruise_hold (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tch_pkg::PADDR_W-1:0]   paddr,
    input  logic [tch_pkg::DATA_W-1:0]    pwdata,
    output logic [tch_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [tch_pkg::ADC_BITS-1:0]  adc_sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [tch_pkg::DUTY_W-1:0]    duty,
    output logic [tch_pkg::MODE_W-1:0]    mode
);
    import tch_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_MAP_MUL,
        ST_MAP_END,
        ST_DB,
        ST_DB_MUL,
        ST_DB_END,
        ST_UPDATE
    } state_t;

    // configuration
    logic                  use_filter_reg;
    logic [ADC_BITS-1:0]   map_start_reg;
    logic [GAIN_W-1:0]     map_gain_reg;
    logic [THR_W-1:0]      dead_thr_reg;
    logic [DGAIN_W-1:0]    dead_gain_reg;
    logic [DUTY_W-1:0]     hold_border_reg;
    logic [RET_W-1:0]      ret_ticks_reg;

    // datapath and control
    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [2:0]            rem_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [LEVEL_W-1:0]    filt_reg;
    logic [MUL_W-1:0]      mul_reg;
    logic [GAIN_W-1:0]     mcand_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [DUTY_W-1:0]     dval_reg;
    logic [DUTY_W-1:0]     t_reg;
    mode_t                 cruise_mode_reg;
    logic [RC_W-1:0]       release_count_reg;
    logic [DUTY_W-1:0]     peak_duty_reg;
    logic                  result_valid_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic [MODE_W-1:0]     mode_reg;

    logic                  cfg_write;
    logic                  cnt_last;
    logic                  out_free;
    logic [3:0]            div_trial;
    logic                  div_ge;
    logic [2:0]            rem_next;
    logic [NUM_W-1:0]      num_next;
    logic [ACC_W-1:0]      acc_next;
    logic [MUL_W-1:0]      mul_next;
    logic [LEVEL_W:0]      diff_raw;
    logic [LEVEL_W:0]      diff_neg;
    logic                  diff_is_neg;
    logic [LEVEL_W-1:0]    diff_mag;
    logic [GAIN_W-1:0]     gain_mag;
    logic                  map_pos;
    logic [ACC_W:0]        map_round;
    logic [ACC_W-MAP_SHIFT:0] map_q;
    logic [DUTY_W-1:0]     map_duty;
    logic [ACC_W:0]        db_round;
    logic [ACC_W-DB_SHIFT:0] db_r;
    logic [DUTY_W-1:0]     db_duty;
    logic [RC_W-1:0]       rc_inc;
    logic [DUTY_W-1:0]     pk_max;
    logic                  t_zero;
    mode_t                 mode_next;
    logic [RC_W-1:0]       rc_next;
    logic [DUTY_W-1:0]     peak_next;
    logic [DUTY_W-1:0]     duty_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_filter_reg  <= 1'b0;
            map_start_reg   <= MAP_START_RST;
            map_gain_reg    <= MAP_GAIN_RST;
            dead_thr_reg    <= DEAD_THR_RST;
            dead_gain_reg   <= DEAD_GAIN_RST;
            hold_border_reg <= HOLD_BORDER_RST;
            ret_ticks_reg   <= RET_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                REG_USE_FILTER:  use_filter_reg  <= pwdata[0];
                REG_MAP_START:   map_start_reg   <= pwdata[ADC_BITS-1:0];
                REG_MAP_GAIN:    map_gain_reg    <= pwdata[GAIN_W-1:0];
                REG_DEAD_THR:    dead_thr_reg    <= pwdata[THR_W-1:0];
                REG_DEAD_GAIN:   dead_gain_reg   <= pwdata[DGAIN_W-1:0];
                REG_HOLD_BORDER: hold_border_reg <= pwdata[DUTY_W-1:0];
                REG_RET_TICKS:   ret_ticks_reg   <= pwdata[RET_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_USE_FILTER:  prdata = DATA_W'(use_filter_reg);
            REG_MAP_START:   prdata = DATA_W'(map_start_reg);
            REG_MAP_GAIN:    prdata = DATA_W'(map_gain_reg);
            REG_DEAD_THR:    prdata = DATA_W'(dead_thr_reg);
            REG_DEAD_GAIN:   prdata = DATA_W'(dead_gain_reg);
            REG_HOLD_BORDER: prdata = DATA_W'(hold_border_reg);
            REG_RET_TICKS:   prdata = DATA_W'(ret_ticks_reg);
            default:         prdata = '0;
        endcase
    end

    // bit-serial divide by five, restoring, msb first
    assign div_trial = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge    = div_trial >= 4'(DIV_BY);
    assign rem_next  = div_ge ? 3'(div_trial - 4'(DIV_BY)) : div_trial[2:0];
    assign num_next  = {num_reg[NUM_W-2:0], div_ge};

    // shared shift-add multiplier, msb first
    assign acc_next = {acc_reg[ACC_W-2:0], 1'b0}
                    + (mul_reg[MUL_W-1] ? ACC_W'(mcand_reg) : ACC_W'(0));
    assign mul_next = {mul_reg[MUL_W-2:0], 1'b0};
    assign cnt_last = cnt_reg == CNT_W'(1);

    // map operands in sign and magnitude
    assign diff_raw    = {1'b0, level_reg} - {1'b0, map_start_reg, 8'b0};
    assign diff_neg    = (LEVEL_W + 1)'(0) - diff_raw;
    assign diff_is_neg = diff_raw[LEVEL_W];
    assign diff_mag    = diff_is_neg ? diff_neg[LEVEL_W-1:0] : diff_raw[LEVEL_W-1:0];
    assign gain_mag    = map_gain_reg[GAIN_W-1] ? GAIN_W'(0) - map_gain_reg : map_gain_reg;
    assign map_pos     = (diff_raw != '0) && (map_gain_reg != '0)
                       && (diff_is_neg == map_gain_reg[GAIN_W-1]);

    assign map_round = {1'b0, acc_reg} + (ACC_W + 1)'(1 << (MAP_SHIFT - 1));
    assign map_q     = map_round[ACC_W:MAP_SHIFT];
    assign map_duty  = (map_q > (ACC_W - MAP_SHIFT + 1)'(DUTY_ONE)) ? DUTY_ONE
                                                                  : map_q[DUTY_W-1:0];

    assign db_round = {1'b0, acc_reg} + (ACC_W + 1)'(1 << (DB_SHIFT - 1));
    assign db_r     = db_round[ACC_W:DB_SHIFT];
    assign db_duty  = (db_r >= (ACC_W - DB_SHIFT + 1)'(DUTY_ONE)) ? DUTY_W'(0)
                                                                : DUTY_ONE - db_r[DUTY_W-1:0];

    // cruise mode update
    assign t_zero = t_reg == '0;
    assign pk_max = (t_reg > peak_duty_reg) ? t_reg : peak_duty_reg;
    assign rc_inc = (release_count_reg == RC_MAX) ? release_count_reg
                                                  : release_count_reg + RC_W'(1);

    always_comb
    begin
        mode_next = cruise_mode_reg;
        rc_next   = release_count_reg;
        peak_next = peak_duty_reg;
        duty_next = t_reg;
        unique case (cruise_mode_reg)
            MODE_IDLE:
            begin
                duty_next = '0;
                if (!t_zero)
                    mode_next = MODE_THROTTLE;
            end
            MODE_THROTTLE:
            begin
                if (t_zero)
                begin
                    mode_next = MODE_RELEASED;
                    rc_next   = '0;
                end
            end
            MODE_RELEASED:
            begin
                rc_next = rc_inc;
                if (rc_inc > {1'b0, ret_ticks_reg})
                    mode_next = MODE_IDLE;
                if (!t_zero)
                begin
                    mode_next = MODE_PEAK;
                    peak_next = '0;
                end
            end
            MODE_PEAK:
            begin
                peak_next = pk_max;
                if (pk_max >= hold_border_reg)
                    duty_next = pk_max;
                if (t_zero)
                    mode_next = (pk_max >= hold_border_reg) ? MODE_HOLD : MODE_IDLE;
            end
            MODE_HOLD:
            begin
                duty_next = peak_duty_reg;
                if (!t_zero)
                    mode_next = MODE_CANCEL;
            end
            MODE_CANCEL:
            begin
                if (t_zero)
                    mode_next = MODE_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free     = !result_valid_reg || result_ready;
    assign sample_ready = state_reg == ST_IDLE;
    assign result_valid = result_valid_reg;
    assign duty         = duty_reg;
    assign mode         = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            num_reg           <= '0;
            rem_reg           <= '0;
            level_reg         <= '0;
            filt_reg          <= '0;
            mul_reg           <= '0;
            mcand_reg         <= '0;
            acc_reg           <= '0;
            dval_reg          <= '0;
            t_reg             <= '0;
            cruise_mode_reg   <= MODE_IDLE;
            release_count_reg <= '0;
            peak_duty_reg     <= '0;
            result_valid_reg  <= 1'b0;
            duty_reg          <= '0;
            mode_reg          <= '0;
        end
        else
        begin
            if (state_reg == ST_UPDATE && out_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && result_ready)
                result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        if (use_filter_reg)
                        begin
                            num_reg   <= NUM_W'({adc_sample, 8'b0}) + NUM_W'({filt_reg, 2'b0})
                                       + NUM_W'(2);
                            rem_reg   <= '0;
                            cnt_reg   <= CNT_W'(NUM_W);
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            level_reg <= {adc_sample, 8'b0};
                            state_reg <= ST_MAP;
                        end
                    end
                end
                ST_DIV:
                begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_last)
                    begin
                        level_reg <= num_next[LEVEL_W-1:0];
                        filt_reg  <= num_next[LEVEL_W-1:0];
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP:
                begin
                    if (map_pos)
                    begin
                        mul_reg   <= diff_mag;
                        mcand_reg <= gain_mag;
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(LEVEL_W);
                        state_reg <= ST_MAP_MUL;
                    end
                    else
                    begin
                        dval_reg  <= '0;
                        state_reg <= ST_DB;
                    end
                end
                ST_MAP_MUL:
                begin
                    acc_reg <= acc_next;
                    mul_reg <= mul_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_last)
                        state_reg <= ST_MAP_END;
                end
                ST_MAP_END:
                begin
                    dval_reg  <= map_duty;
                    state_reg <= ST_DB;
                end
                ST_DB:
                begin
                    if (dval_reg < {1'b0, dead_thr_reg})
                    begin
                        t_reg     <= '0;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        mul_reg   <= MUL_W'(DUTY_ONE - dval_reg) << (MUL_W - DUTY_W);
                        mcand_reg <= GAIN_W'(dead_gain_reg);
                        acc_reg   <= '0;
                        cnt_reg   <= CNT_W'(DUTY_W);
                        state_reg <= ST_DB_MUL;
                    end
                end
                ST_DB_MUL:
                begin
                    acc_reg <= acc_next;
                    mul_reg <= mul_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_last)
                        state_reg <= ST_DB_END;
                end
                ST_DB_END:
                begin
                    t_reg     <= db_duty;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    if (out_free)
                    begin
                        cruise_mode_reg   <= mode_next;
                        release_count_reg <= rc_next;
                        peak_duty_reg     <= peak_next;
                        duty_reg          <= duty_next;
                        mode_reg          <= mode_next;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/tch_checker.sv =====
// port-level assertions for throttle_cruise_hold, bound to the top level
// depends on tch_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tch_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_valid,
    input logic                        sample_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [tch_pkg::DUTY_W-1:0]  duty,
    input logic [tch_pkg::MODE_W-1:0]  mode
);
    import tch_pkg::*;

    // one item at a time
    `TCH_ASSERT_NEXT(a_busy_after_take, clk, rst_n, sample_valid && sample_ready, !sample_ready, "sample taken while busy")
    `TCH_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(duty) && $stable(mode), "stalled result changed")
    `TCH_ASSERT_IMPL(a_duty_range, clk, rst_n, result_valid, duty <= DUTY_ONE, "duty above full scale")
    // idle and released always drive zero duty
    `TCH_ASSERT_IMPL(a_idle_zero, clk, rst_n, result_valid && (mode == MODE_W'(MODE_IDLE) || mode == MODE_W'(MODE_RELEASED)), duty == '0, "nonzero duty in idle or released")

endmodule

bind throttle_cruise_hold tch_checker u_tch_checker (.*);
